FILE: design/aflm_pkg.sv
// ----------------------------------------------------------------------------
// aflm_pkg: shared types and constants for the frame level meter
// Fixed field widths and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aflm_pkg;

    // slot word and sample format
    localparam int WORD_W   = 32;
    localparam int SHIFT_W  = 8;
    localparam int SAMPLE_W = WORD_W - SHIFT_W;

    // running sum and result fields
    localparam int SUM_W    = 32;
    localparam int FS_W     = 9;
    localparam int STEP_W   = $clog2(SUM_W);

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // take the request on the sample port
        logic div_step;   // one quotient bit of the mean divide
        logic load_out;   // move the finished frame into the result register
    } aflm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic close;      // present request closes the frame
        logic div_last;   // last quotient bit in this step
        logic out_free;   // result register can take a new frame
    } aflm_sts_t;

endpackage : aflm_pkg

`default_nettype wire

FILE: design/aflm_ctrl.sv
// ----------------------------------------------------------------------------
// aflm_ctrl: frame level meter controller
// Sequences sample accumulation, the bit-serial mean divide and the hand-off
// of each closed frame to the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aflm_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire aflm_pkg::aflm_sts_t sts,
    output aflm_pkg::aflm_cmd_t     cmd
);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_FIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        sample_ready = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_RUN:
            begin
                sample_ready = 1'b1;
                cmd.accept   = sample_valid;
                if (sample_valid && sts.close)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule : aflm_ctrl

`default_nettype wire

FILE: design/aflm_datapath.sv
// ----------------------------------------------------------------------------
// aflm_datapath: frame level meter datapath
// Sample magnitude, saturating sum, peak and count accumulators, a restoring
// divider that yields one mean bit per cycle, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aflm_datapath
#(
    parameter int MAX_FRAME = 256,
    parameter int CNT_W     = 9
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic signed [aflm_pkg::WORD_W-1:0]  slot_word,
    input  wire logic                                frame_end,
    input  wire aflm_pkg::aflm_cmd_t                 cmd,
    output aflm_pkg::aflm_sts_t                      sts,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic [aflm_pkg::SAMPLE_W-1:0]            mean_magnitude,
    output logic [aflm_pkg::SAMPLE_W-1:0]            peak_magnitude,
    output logic [aflm_pkg::FS_W-1:0]                frame_samples
);

    localparam int SAMPLE_W = aflm_pkg::SAMPLE_W;
    localparam int SUM_W    = aflm_pkg::SUM_W;
    localparam int STEP_W   = aflm_pkg::STEP_W;
    localparam int FS_W     = aflm_pkg::FS_W;

    // frame accumulators
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // divider and frame snapshot
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SAMPLE_W-1:0] fpeak_reg;
    logic [CNT_W-1:0]    fcnt_reg;

    // result register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0] opeak_reg;
    logic [FS_W-1:0]     ocnt_reg;

    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] peak_next;
    logic [CNT_W-1:0]    cnt_next;
    logic [CNT_W:0]      rem_shift;
    logic                rem_ge;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W+FS_W-1:0] fcnt_ext;

    // magnitude of the 24-bit sample in the upper bits of the slot word
    assign sample = slot_word[aflm_pkg::WORD_W-1:aflm_pkg::SHIFT_W];
    assign mag    = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

    // accumulate with saturation on the sum
    assign sum_wide  = {1'b0, sum_reg} + {{(SUM_W+1-SAMPLE_W){1'b0}}, mag};
    assign sum_next  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign peak_next = (mag > peak_reg) ? mag : peak_reg;
    assign cnt_next  = cnt_reg + 1'b1;

    // restoring divide step
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};
    assign rem_next  = rem_ge ? CNT_W'(rem_shift - {1'b0, divisor_reg})
                              : rem_shift[CNT_W-1:0];

    assign fcnt_ext  = {{FS_W{1'b0}}, fcnt_reg};

    // status to the controller
    assign sts.close    = frame_end || (cnt_next >= CNT_W'(MAX_FRAME));
    assign sts.div_last = (step_reg == {STEP_W{1'b1}});
    assign sts.out_free = !out_valid_reg || result_ready;

    // frame accumulators, cleared when a frame closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (sts.close)
            begin
                sum_reg  <= '0;
                peak_reg <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                peak_reg <= peak_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // snapshot of the closing frame and the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.accept && sts.close)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && sts.close)
        begin
            quo_reg     <= sum_next;
            rem_reg     <= '0;
            divisor_reg <= cnt_next;
            fpeak_reg   <= peak_next;
            fcnt_reg    <= cnt_next;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            mean_reg  <= quo_reg[SAMPLE_W-1:0];
            opeak_reg <= fpeak_reg;
            ocnt_reg  <= fcnt_ext[FS_W-1:0];
        end
    end

    assign result_valid   = out_valid_reg;
    assign mean_magnitude = mean_reg;
    assign peak_magnitude = opeak_reg;
    assign frame_samples  = ocnt_reg;

endmodule : aflm_datapath

`default_nettype wire

FILE: design/audio_frame_level_meter_unit.sv
// ----------------------------------------------------------------------------
// audio_frame_level_meter_unit: mean absolute and peak level meter
// Accumulates sample magnitudes over a frame and reports mean, peak and count.
// ----------------------------------------------------------------------------
// Each sample request carries a 32-bit slot word whose upper 24 bits are a
// two's complement sample. Within a frame one request is taken per cycle.
// The request marked frame_end, or the MAX_FRAME-th sample, closes the frame:
// the block then runs a restoring divider (one mean bit per cycle) and then
// hands the frame to the result register, waiting first if the previous
// result has not yet been taken; the sample port is not ready meanwhile. The
// sum saturates at 32 bits, frame_samples carries the low 9 bits of the count.
`timescale 1ns / 1ps
`default_nettype none

module audio_frame_level_meter_unit
#(
    parameter int MAX_FRAME = 256
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire logic signed [aflm_pkg::WORD_W-1:0]  slot_word,
    input  wire logic                                frame_end,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic [aflm_pkg::SAMPLE_W-1:0]            mean_magnitude,
    output logic [aflm_pkg::SAMPLE_W-1:0]            peak_magnitude,
    output logic [aflm_pkg::FS_W-1:0]                frame_samples
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    aflm_pkg::aflm_cmd_t cmd;
    aflm_pkg::aflm_sts_t sts;

    // sequencer
    aflm_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // accumulators, divider and result register
    aflm_datapath
    #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .slot_word      (slot_word),
        .frame_end      (frame_end),
        .cmd            (cmd),
        .sts            (sts),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .mean_magnitude (mean_magnitude),
        .peak_magnitude (peak_magnitude),
        .frame_samples  (frame_samples)
    );

endmodule : audio_frame_level_meter_unit

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: frame level meter testbench
// Sends slot word requests split into frames and predicts mean, peak and
// count for every frame closed by frame_end or by the frame size limit.
// Results are checked in order. Phases vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int FRAME_LIMIT = 256;

    typedef struct {
        logic [aflm_pkg::WORD_W-1:0] word;
        logic                        last;
    } sample_req_t;

    typedef struct {
        logic [aflm_pkg::SAMPLE_W-1:0] mean;
        logic [aflm_pkg::SAMPLE_W-1:0] peak;
        logic [aflm_pkg::FS_W-1:0]     count;
    } frame_level_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                sample_valid = 1'b0;
    logic                                sample_ready;
    logic signed [aflm_pkg::WORD_W-1:0]  slot_word = '0;
    logic                                frame_end = 1'b0;
    logic                                result_valid;
    logic                                result_ready = 1'b0;
    logic [aflm_pkg::SAMPLE_W-1:0]       mean_magnitude;
    logic [aflm_pkg::SAMPLE_W-1:0]       peak_magnitude;
    logic [aflm_pkg::FS_W-1:0]           frame_samples;

    // pending requests and expected frame levels
    sample_req_t  pending_reqs[$];
    frame_level_t level_expect[$];

    // running frame state of the predictor
    logic [aflm_pkg::SUM_W-1:0]    frame_sum = '0;
    logic [aflm_pkg::SAMPLE_W-1:0] frame_peak = '0;
    int                            frame_count = 0;

    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic holdoff_go = 1'b0;
    logic holdoff_used = 1'b0;
    int   holdoff_left = 0;
    int   mismatch_count = 0;

    audio_frame_level_meter_unit #(
        .MAX_FRAME(FRAME_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .slot_word     (slot_word),
        .frame_end     (frame_end),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .mean_magnitude(mean_magnitude),
        .peak_magnitude(peak_magnitude),
        .frame_samples (frame_samples)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fold one accepted sample into the frame, close it when due
    task automatic take_sample(input logic [aflm_pkg::WORD_W-1:0] word, input logic last);
        logic [aflm_pkg::SAMPLE_W-1:0] smp;
        logic [aflm_pkg::SAMPLE_W-1:0] mag;
        logic [aflm_pkg::SUM_W:0]      wide;
        frame_level_t                  lvl;
        smp = word[aflm_pkg::WORD_W-1:aflm_pkg::SHIFT_W];
        mag = smp[aflm_pkg::SAMPLE_W-1] ? (~smp + 1'b1) : smp;
        wide = {1'b0, frame_sum} + mag;
        frame_sum = wide[aflm_pkg::SUM_W] ? '1 : wide[aflm_pkg::SUM_W-1:0];
        if (mag > frame_peak)
            frame_peak = mag;
        frame_count++;
        if (last || frame_count >= FRAME_LIMIT)
        begin
            lvl.mean = aflm_pkg::SAMPLE_W'(frame_sum / frame_count);
            lvl.peak = frame_peak;
            lvl.count = aflm_pkg::FS_W'(frame_count);
            level_expect.push_back(lvl);
            frame_sum = '0;
            frame_peak = '0;
            frame_count = 0;
        end
    endtask

    // sender: present queued requests, with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            slot_word <= '0;
            frame_end <= 1'b0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                take_sample(slot_word, frame_end);
            if (!sample_valid || sample_ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    slot_word <= pending_reqs[0].word;
                    frame_end <= pending_reqs[0].last;
                    void'(pending_reqs.pop_front());
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, armed once
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_used <= 1'b0;
        end
        else if (holdoff_go && !holdoff_used)
        begin
            holdoff_left <= 400;
            holdoff_used <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // receiver: check each result against the oldest expectation
    always @(posedge clk)
    begin
        frame_level_t lvl;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                if (level_expect.size() == 0)
                begin
                    $error("tb: result with no frame pending");
                    mismatch_count++;
                end
                else
                begin
                    lvl = level_expect.pop_front();
                    if (mean_magnitude !== lvl.mean)
                    begin
                        $error("mean_magnitude: expected %0d, got %0d", lvl.mean, mean_magnitude);
                        mismatch_count++;
                    end
                    if (peak_magnitude !== lvl.peak)
                    begin
                        $error("peak_magnitude: expected %0d, got %0d", lvl.peak, peak_magnitude);
                        mismatch_count++;
                    end
                    if (frame_samples !== lvl.count)
                    begin
                        $error("frame_samples: expected %0d, got %0d", lvl.count, frame_samples);
                        mismatch_count++;
                    end
                end
            end
            result_ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_req(input logic [aflm_pkg::WORD_W-1:0] word, input logic last);
        sample_req_t req;
        req.word = word;
        req.last = last;
        pending_reqs.push_back(req);
    endtask

    // slot word biased toward the sample extremes and small levels
    function automatic logic [aflm_pkg::WORD_W-1:0] pick_word();
        logic [7:0]                  junk;
        logic [aflm_pkg::WORD_W-1:0] w;
        junk = 8'($urandom);
        case ($urandom_range(0, 5))
            0: w = {24'h800000, junk};
            1: w = {24'h7FFFFF, junk};
            2: w = {24'($urandom_range(0, 600)), junk};
            3: w = {-24'($urandom_range(1, 600)), junk};
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // whole frames of random length until the item budget is used
    task automatic push_frames(input int budget);
        int n;
        int len;
        n = 0;
        while (n < budget)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                push_req(pick_word(), i == len - 1);
            n += len;
        end
    endtask

    // wait until every request is sent and every result is back
    task automatic drain();
        while (!(pending_reqs.size() == 0 && !sample_valid && level_expect.size() == 0))
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single-sample frames at the field extremes, low byte ignored
        push_req(32'h0000_0000, 1'b1);
        push_req(32'h8000_0000, 1'b1);
        push_req(32'h7FFF_FFFF, 1'b1);
        push_req(32'hFFFF_FFFF, 1'b1);
        push_req(32'h0000_00FF, 1'b1);
        push_req(32'h8000_00AB, 1'b1);
        // mixed signs, most negative sample sets the peak
        push_req(32'h8000_0000, 1'b0);
        push_req(32'h7FFF_FF00, 1'b0);
        push_req(32'h0000_0100, 1'b1);
        // mean rounds down
        push_req(32'h0000_0100, 1'b0);
        push_req(32'h0000_0100, 1'b0);
        push_req(32'h0000_0100, 1'b0);
        push_req(32'h0000_0200, 1'b1);
        push_req(32'hFFFF_FE00, 1'b0);
        push_req(32'h0000_0355, 1'b1);
        // frame closed by the size limit, then a fresh one
        for (int i = 0; i < FRAME_LIMIT; i++)
            push_req(pick_word(), 1'b0);
        push_req(32'hFFFF_FF00, 1'b1);
        drain();

        // no gaps, receiver holds off long enough to back up the input
        holdoff_go <= 1'b1;
        push_frames(80);
        drain();

        sender_idle_pct <= 81;
        push_frames(40);
        drain();

        sender_idle_pct <= 0;
        recv_stall_pct <= 81;
        push_frames(40);
        drain();

        sender_idle_pct <= 33;
        recv_stall_pct <= 33;
        push_frames(40);
        drain();

        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
design/aflm_pkg.sv
design/aflm_ctrl.sv
design/aflm_datapath.sv
design/audio_frame_level_meter_unit.sv
bench/tb.sv
